### hdl/i2c_master_byte_controller_defines.svh
// Assertion macros for the I2C master byte controller.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_BYTE_CONTROLLER_DEFINES_SVH
`define I2C_MASTER_BYTE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte controller.
// No dependencies; every file but the defines header imports it.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int TIMING_WIDTH = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int BIT_IDX_W    = 4;

	// Index of the acknowledge bit within a byte transfer.
	localparam logic [BIT_IDX_W-1:0] ACK_BIT = BIT_IDX_W'(8);

	localparam logic [CFG_IDX_W-1:0] REG_PRE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_POST     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ACK_HIGH = CFG_IDX_W'(3);

	localparam logic [TIMING_WIDTH-1:0] PRE_RST      = TIMING_WIDTH'(3);
	localparam logic [TIMING_WIDTH-1:0] HIGH_RST     = TIMING_WIDTH'(3);
	localparam logic [TIMING_WIDTH-1:0] POST_RST     = TIMING_WIDTH'(3);
	localparam logic [TIMING_WIDTH-1:0] ACK_HIGH_RST = TIMING_WIDTH'(12);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic [TIMING_WIDTH-1:0] pre_ticks;
		logic [TIMING_WIDTH-1:0] high_ticks;
		logic [TIMING_WIDTH-1:0] post_ticks;
		logic [TIMING_WIDTH-1:0] ack_high_ticks;
	} timing_t;

	typedef struct packed {
		logic       cmd_valid;
		op_t        operation;
		logic [7:0] tx_byte;
		logic       master_ack;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       slave_nack;
	} res_item_t;

endpackage

### hdl/i2cm_cmd_if.sv
// Tick channel into the controller: valid, ready and one tick item.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

interface i2cm_cmd_if;
	import i2cm_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### hdl/i2cm_res_if.sv
// Result channel out of the controller: valid, ready and one result item.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

interface i2cm_res_if;
	import i2cm_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### hdl/i2cm_cfg.sv
// Timing register file of the I2C master byte controller.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2cm_pkg::TIMING_WIDTH-1:0]  cfg_wdata,
	output i2cm_pkg::timing_t                  timing
);
	import i2cm_pkg::*;

	timing_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.pre_ticks      <= PRE_RST;
			timing_q.high_ticks     <= HIGH_RST;
			timing_q.post_ticks     <= POST_RST;
			timing_q.ack_high_ticks <= ACK_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRE:      timing_q.pre_ticks      <= cfg_wdata;
				REG_HIGH:     timing_q.high_ticks     <= cfg_wdata;
				REG_POST:     timing_q.post_ticks     <= cfg_wdata;
				REG_ACK_HIGH: timing_q.ack_high_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign timing = timing_q;
endmodule

### hdl/i2cm_core.sv
// Bit sequencer of the I2C master: phase, counters and line levels,
// advanced by one tick per step. Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  i2cm_pkg::cmd_item_t  item,
	input  i2cm_pkg::timing_t    timing,
	output i2cm_pkg::res_item_t  result
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_SET  = 4'd1,
		PH_START_HOLD = 4'd2,
		PH_STOP_LOW   = 4'd3,
		PH_STOP_HIGH  = 4'd4,
		PH_STOP_POST  = 4'd5,
		PH_BIT_PRE    = 4'd6,
		PH_BIT_HIGH   = 4'd7,
		PH_BIT_POST   = 4'd8
	} phase_t;

	phase_t                  phase_q, phase_d;
	op_t                     op_q, op_d;
	logic [BIT_IDX_W-1:0]    bit_idx_q, bit_idx_d;
	logic [TIMING_WIDTH-1:0] tick_q, tick_d;
	logic [7:0]              shift_q, shift_d;
	logic                    ack_q, ack_d;
	logic                    scl_q, scl_d;
	logic                    sda_q, sda_d;
	logic                    nack_q, nack_d;
	logic [7:0]              rx_q, rx_d;
	logic                    done_q, done_d;

	logic [TIMING_WIDTH-1:0] limit;
	logic [TIMING_WIDTH:0]   cnt_next;
	logic                    over;
	logic [TIMING_WIDTH-1:0] tick_after;

	// SDA level for a bit: data on the first eight, acknowledge on the ninth.
	function automatic logic bit_level(op_t op, logic [BIT_IDX_W-1:0] idx,
			logic [7:0] sb, logic ack);
		logic lvl;
		if (idx < ACK_BIT) begin
			lvl = (op == OP_WRITE) ? sb[7] : 1'b1;
		end else begin
			lvl = (op == OP_WRITE) ? 1'b1 : ~ack;
		end
		return lvl;
	endfunction

	always_comb begin
		unique case (phase_q)
			PH_START_SET, PH_STOP_LOW, PH_BIT_PRE: limit = timing.pre_ticks;
			PH_STOP_HIGH: limit = timing.high_ticks;
			PH_BIT_HIGH: limit = (bit_idx_q >= ACK_BIT) ? timing.ack_high_ticks
				: timing.high_ticks;
			default: limit = timing.post_ticks;
		endcase
	end

	// A limit of zero ends the wait on the first tick, just like one.
	assign cnt_next   = {1'b0, tick_q} + 1'b1;
	assign over       = cnt_next >= {1'b0, limit};
	assign tick_after = over ? '0 : cnt_next[TIMING_WIDTH-1:0];

	always_comb begin
		phase_d   = phase_q;
		op_d      = op_q;
		bit_idx_d = bit_idx_q;
		tick_d    = tick_q;
		shift_d   = shift_q;
		ack_d     = ack_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		nack_d    = nack_q;
		rx_d      = rx_q;
		done_d    = 1'b0;
		unique case (phase_q)
			PH_START_SET: begin
				tick_d = tick_after;
				if (over) begin
					sda_d   = 1'b0;
					phase_d = PH_START_HOLD;
				end
			end
			PH_START_HOLD: begin
				tick_d = tick_after;
				if (over) begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			PH_STOP_LOW: begin
				tick_d = tick_after;
				if (over) begin
					scl_d   = 1'b1;
					phase_d = PH_STOP_HIGH;
				end
			end
			PH_STOP_HIGH: begin
				tick_d = tick_after;
				if (over) begin
					sda_d   = 1'b1;
					phase_d = PH_STOP_POST;
				end
			end
			PH_STOP_POST: begin
				tick_d = tick_after;
				if (over) begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			PH_BIT_PRE: begin
				tick_d = tick_after;
				if (over) begin
					scl_d   = 1'b1;
					phase_d = PH_BIT_HIGH;
				end
			end
			PH_BIT_HIGH: begin
				tick_d = tick_after;
				if (over) begin
					if (bit_idx_q < ACK_BIT) begin
						shift_d = {shift_q[6:0], (op_q == OP_WRITE) ? 1'b0 : item.sda_in};
					end else if (op_q == OP_WRITE) begin
						nack_d = item.sda_in;
					end
					scl_d   = 1'b0;
					phase_d = PH_BIT_POST;
				end
			end
			PH_BIT_POST: begin
				tick_d = tick_after;
				if (over) begin
					if (bit_idx_q >= ACK_BIT) begin
						if (op_q == OP_READ) begin
							rx_d = shift_q;
						end
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else begin
						bit_idx_d = bit_idx_q + 1'b1;
						sda_d     = bit_level(op_q, bit_idx_d, shift_q, ack_q);
						phase_d   = PH_BIT_PRE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.cmd_valid) begin
					op_d   = item.operation;
					tick_d = '0;
					unique case (item.operation)
						OP_START: begin
							sda_d   = 1'b1;
							scl_d   = 1'b1;
							phase_d = PH_START_SET;
						end
						OP_STOP: begin
							sda_d   = 1'b0;
							phase_d = PH_STOP_LOW;
						end
						default: begin
							shift_d   = (item.operation == OP_WRITE) ? item.tx_byte : 8'h00;
							ack_d     = item.master_ack;
							bit_idx_d = '0;
							sda_d     = bit_level(item.operation, bit_idx_d, shift_d,
								item.master_ack);
							phase_d   = PH_BIT_PRE;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			op_q      <= OP_START;
			bit_idx_q <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			nack_q    <= 1'b0;
			rx_q      <= '0;
			done_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			op_q      <= op_d;
			bit_idx_q <= bit_idx_d;
			tick_q    <= tick_d;
			shift_q   <= shift_d;
			ack_q     <= ack_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			nack_q    <= nack_d;
			rx_q      <= rx_d;
			done_q    <= done_d;
		end
	end

	// The state registers hold still between steps, so they double as the
	// result register.
	assign result.scl_out    = scl_q;
	assign result.sda_out    = sda_q;
	assign result.busy_res   = (phase_q != PH_IDLE);
	assign result.done_res   = done_q;
	assign result.rx_byte    = rx_q;
	assign result.slave_nack = nack_q;
endmodule

### hdl/i2c_master_byte_controller.sv
// I2C master byte controller, tick-driven.
// Every item on cmd is one timebase tick: the sampled SDA level plus an
// optional command (start, stop, write byte, read byte with ACK or NACK).
// Every accepted item yields exactly one result item on res with the SCL
// and SDA drive levels, busy, a one-item done pulse, the last received
// byte and the slave NACK flag of the last write.
// A command offered while a command is running is ignored.
// Throughput: one tick per clock cycle unless res stalls; the input
// register and the sequencer state step together, so nothing iterates
// inside a tick. If res stalls, the waiting result holds, one more tick
// is taken into the input register, and cmd.ready then drops until res
// moves again. Reset releases both lines, clears the sequencer, empties
// both registers and loads the timing defaults (3, 3, 3, 12). Timing
// registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle, which is not enforced.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if, i2cm_cfg, i2cm_core.
`timescale 1ns / 1ps
`include "i2c_master_byte_controller_defines.svh"

module i2c_master_byte_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	i2cm_cmd_if.sink                          cmd,
	i2cm_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cm_pkg::TIMING_WIDTH-1:0] cfg_wdata
);
	import i2cm_pkg::*;

	cmd_item_t cmd_item_s1;
	logic      cmd_valid_s1;
	logic      res_valid_q;
	logic      advance;
	timing_t   timing;
	res_item_t result;

	assign advance   = cmd_valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.ready) begin
				cmd_valid_s1 <= cmd.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_item_s1 <= cmd.item;
		end
	end

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.timing    (timing)
	);

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (cmd_item_s1),
		.timing (timing),
		.result (result)
	);

	assign res.valid = res_valid_q;
	assign res.item  = result;

	`I2CM_ASSERT_IMP(a_done_not_busy, clk, arst_n, res.valid && res.item.done_res, !res.item.busy_res, "done reported while still busy")
	`I2CM_ASSERT_NXT(a_done_single, clk, arst_n, res.valid && res.ready && res.item.done_res, !(res.valid && res.item.done_res), "done pulse repeated")
	`I2CM_ASSERT_IMP(a_full_stall, clk, arst_n, cmd_valid_s1 && res_valid_q && !res.ready, !cmd.ready, "item taken while both registers are full")
	`I2CM_ASSERT_NXT(a_step_result, clk, arst_n, advance, res.valid, "stepped tick produced no result")
endmodule

### sim/i2cm_checker.sv
// Checker for the I2C master byte controller: predicts the bus levels for every tick item.
// It compares each result item with the oldest prediction.
// Depends on i2cm_pkg, i2cm_cmd_if and i2cm_res_if.
`timescale 1ns / 1ps

module i2cm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	i2cm_cmd_if                               cmd,
	i2cm_res_if                               res,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cm_pkg::TIMING_WIDTH-1:0] cfg_wdata,
	output int                                fail_count,
	output int                                pending,
	output logic                              line_idle
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_SET,
		PH_START_HOLD,
		PH_STOP_LOW,
		PH_STOP_HIGH,
		PH_STOP_POST,
		PH_BIT_PRE,
		PH_BIT_HIGH,
		PH_BIT_POST
	} bus_phase_t;

	timing_t                 timing;
	bus_phase_t              phase;
	op_t                     held_op;
	logic [BIT_IDX_W-1:0]    bit_no;
	logic [TIMING_WIDTH-1:0] wait_cnt;
	logic [7:0]              shift_reg;
	logic                    ack_drive;
	logic                    scl_lvl;
	logic                    sda_lvl;
	logic                    nack_seen;
	logic [7:0]              rx_last;
	int                      mismatches;
	res_item_t               bus_level_q[$];

	// A wait of len ticks ends on the len-th tick; a length of zero acts as one.
	function automatic logic timer_done(input logic [TIMING_WIDTH-1:0] len);
		logic [TIMING_WIDTH:0] nxt;
		nxt = {1'b0, wait_cnt} + 1'b1;
		if (nxt >= {1'b0, len}) begin
			wait_cnt = '0;
			return 1'b1;
		end
		wait_cnt = nxt[TIMING_WIDTH-1:0];
		return 1'b0;
	endfunction

	function automatic logic drive_level();
		if (bit_no < ACK_BIT)
			return (held_op == OP_WRITE) ? shift_reg[7] : 1'b1;
		if (held_op == OP_WRITE)
			return 1'b1;
		return !ack_drive;
	endfunction

	function automatic res_item_t advance_bus_tick(input cmd_item_t it);
		res_item_t r;
		logic      fin;
		fin = 1'b0;
		case (phase)
			PH_START_SET: if (timer_done(timing.pre_ticks)) begin
				sda_lvl = 1'b0;
				phase = PH_START_HOLD;
			end
			PH_START_HOLD: if (timer_done(timing.post_ticks)) begin
				scl_lvl = 1'b0;
				phase = PH_IDLE;
				fin = 1'b1;
			end
			PH_STOP_LOW: if (timer_done(timing.pre_ticks)) begin
				scl_lvl = 1'b1;
				phase = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: if (timer_done(timing.high_ticks)) begin
				sda_lvl = 1'b1;
				phase = PH_STOP_POST;
			end
			PH_STOP_POST: if (timer_done(timing.post_ticks)) begin
				phase = PH_IDLE;
				fin = 1'b1;
			end
			PH_BIT_PRE: if (timer_done(timing.pre_ticks)) begin
				scl_lvl = 1'b1;
				phase = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: if (timer_done(bit_no >= ACK_BIT ? timing.ack_high_ticks
					: timing.high_ticks)) begin
				// SDA is sampled at the end of the high time.
				if (bit_no < ACK_BIT) begin
					if (held_op == OP_WRITE)
						shift_reg = {shift_reg[6:0], 1'b0};
					else
						shift_reg = {shift_reg[6:0], it.sda_in};
				end else if (held_op == OP_WRITE) begin
					nack_seen = it.sda_in;
				end
				scl_lvl = 1'b0;
				phase = PH_BIT_POST;
			end
			PH_BIT_POST: if (timer_done(timing.post_ticks)) begin
				if (bit_no >= ACK_BIT) begin
					if (held_op == OP_READ)
						rx_last = shift_reg;
					phase = PH_IDLE;
					fin = 1'b1;
				end else begin
					bit_no = bit_no + 1'b1;
					sda_lvl = drive_level();
					phase = PH_BIT_PRE;
				end
			end
			default: begin
				phase = PH_IDLE;
				if (it.cmd_valid) begin
					held_op = it.operation;
					wait_cnt = '0;
					case (it.operation)
						OP_START: begin
							sda_lvl = 1'b1;
							scl_lvl = 1'b1;
							phase = PH_START_SET;
						end
						OP_STOP: begin
							sda_lvl = 1'b0;
							phase = PH_STOP_LOW;
						end
						default: begin
							shift_reg = (it.operation == OP_WRITE) ? it.tx_byte : 8'h00;
							ack_drive = it.master_ack;
							bit_no = '0;
							sda_lvl = drive_level();
							phase = PH_BIT_PRE;
						end
					endcase
				end
			end
		endcase
		r.scl_out = scl_lvl;
		r.sda_out = sda_lvl;
		r.busy_res = (phase != PH_IDLE);
		r.done_res = fin;
		r.rx_byte = rx_last;
		r.slave_nack = nack_seen;
		return r;
	endfunction

	task automatic flag_result(input string why, input res_item_t want, input res_item_t got);
		if (mismatches < 10)
			$display("%0t %s: scl %b/%b sda %b/%b busy %b/%b done %b/%b rx %h/%h nack %b/%b",
				$realtime, why, want.scl_out, got.scl_out, want.sda_out, got.sda_out,
				want.busy_res, got.busy_res, want.done_res, got.done_res,
				want.rx_byte, got.rx_byte, want.slave_nack, got.slave_nack);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		res_item_t got;
		logic      bad;
		if (!arst_n) begin
			timing = '{PRE_RST, HIGH_RST, POST_RST, ACK_HIGH_RST};
			phase = PH_IDLE;
			held_op = OP_START;
			bit_no = '0;
			wait_cnt = '0;
			shift_reg = '0;
			ack_drive = 1'b0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			nack_seen = 1'b0;
			rx_last = '0;
			mismatches = 0;
			bus_level_q.delete();
			fail_count <= 0;
			pending <= 0;
			line_idle <= 1'b1;
		end else begin
			if (res.valid && res.ready) begin
				got = res.item;
				if (bus_level_q.size() == 0) begin
					flag_result("result item with nothing expected (expected/actual)", got, got);
				end else begin
					want = bus_level_q.pop_front();
					bad = (got.scl_out !== want.scl_out) || (got.sda_out !== want.sda_out) ||
						(got.busy_res !== want.busy_res) || (got.done_res !== want.done_res) ||
						(got.rx_byte !== want.rx_byte) || (got.slave_nack !== want.slave_nack);
					if (bad)
						flag_result("result mismatch (expected/actual)", want, got);
				end
			end
			if (cmd.valid && cmd.ready)
				bus_level_q.push_back(advance_bus_tick(cmd.item));
			if (cfg_we) begin
				case (cfg_index)
					REG_PRE:      timing.pre_ticks = cfg_wdata;
					REG_HIGH:     timing.high_ticks = cfg_wdata;
					REG_POST:     timing.post_ticks = cfg_wdata;
					REG_ACK_HIGH: timing.ack_high_ticks = cfg_wdata;
					default: ;
				endcase
			end
			fail_count <= mismatches;
			pending <= bus_level_q.size();
			line_idle <= (phase == PH_IDLE);
		end
	end

endmodule

### sim/tb_i2c_master_byte_controller.sv
// Testbench top for the I2C master byte controller: clock, reset, tick and
// configuration stimulus, result stalls and the final verdict.
// Depends on i2cm_pkg, the two channel interfaces, the block and i2cm_checker.
`timescale 1ns / 1ps

module tb_i2c_master_byte_controller;
	import i2cm_pkg::*;

	localparam int SDA_LOW   = 0;
	localparam int SDA_HIGH  = 1;
	localparam int SDA_RAND  = 2;
	localparam int ITEM_GOAL = 800;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [TIMING_WIDTH-1:0] cfg_wdata;
	int                      fail_count;
	int                      pending;
	logic                    line_idle;
	int                      idle_pct;
	int                      items_sent;
	int                      target;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();

	i2c_master_byte_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	i2cm_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.line_idle  (line_idle)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	function automatic logic pick_sda(input int mode);
		if (mode == SDA_LOW)
			return 1'b0;
		if (mode == SDA_HIGH)
			return 1'b1;
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [TIMING_WIDTH-1:0] rand_len(input int longest);
		if ($urandom_range(9) == 0)
			return '0;
		return TIMING_WIDTH'($urandom_range(longest, 1));
	endfunction

	// A command only takes effect when the controller was idle before this item.
	task automatic send_tick(input cmd_item_t it, output logic took);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.item <= it;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		took = it.cmd_valid && line_idle;
	endtask

	// Offers the command on every item until it is taken, so it also lands
	// on the finishing item of the previous one, which must be ignored.
	task automatic issue(input op_t op, input logic [7:0] data, input logic ack,
			input int sda_mode, input logic wait_idle);
		cmd_item_t it;
		logic      took;
		it.cmd_valid = 1'b1;
		it.operation = op;
		it.tx_byte = data;
		it.master_ack = ack;
		took = 1'b0;
		while (!took) begin
			it.sda_in = pick_sda(sda_mode);
			send_tick(it, took);
		end
		if (wait_idle) begin
			it.cmd_valid = 1'b0;
			forever begin
				it.sda_in = pick_sda(sda_mode);
				send_tick(it, took);
				if (line_idle)
					break;
			end
		end
	endtask

	// Runs the controller idle and lets every result drain.
	task automatic settle();
		cmd_item_t nop;
		logic      took;
		nop = '0;
		forever begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
			wait (pending == 0);
			if (line_idle)
				break;
			nop.sda_in = pick_sda(SDA_RAND);
			send_tick(nop, took);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMING_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic write_timing(input logic [TIMING_WIDTH-1:0] pre, input logic [TIMING_WIDTH-1:0] high,
			input logic [TIMING_WIDTH-1:0] post, input logic [TIMING_WIDTH-1:0] ack_high);
		settle();
		write_reg(REG_PRE, pre);
		write_reg(REG_HIGH, high);
		write_reg(REG_POST, post);
		write_reg(REG_ACK_HIGH, ack_high);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly complete transfers with random content; the rest are lone
	// commands and items with random fields.
	task automatic random_transfer();
		int        kind;
		int        n;
		cmd_item_t it;
		logic      took;
		kind = $urandom_range(99);
		if (kind < 85) begin
			issue(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 1'($urandom));
			n = $urandom_range(2, 1);
			repeat (n)
				issue($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom), 1'($urandom),
					SDA_RAND, 1'($urandom));
			if ($urandom_range(9) != 0)
				issue(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 1'($urandom));
		end else if (kind < 93) begin
			issue(op_t'($urandom_range(3)), 8'($urandom), 1'($urandom), SDA_RAND, 1'($urandom));
		end else begin
			repeat ($urandom_range(8, 1)) begin
				it.cmd_valid = 1'($urandom);
				it.operation = op_t'($urandom_range(3));
				it.tx_byte = 8'($urandom);
				it.master_ack = 1'($urandom);
				it.sda_in = 1'($urandom);
				send_tick(it, took);
			end
		end
		if ($urandom_range(19) == 0)
			settle();
	endtask

	initial begin
		cmd_item_t nop;
		logic      took;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PRE;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.item = '0;
		res_ch.ready = 1'b0;
		idle_pct = 10;
		items_sent = 0;
		nop = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: idle lines hold, then a short transfer. The read is
		// followed at once by the stop, which is offered while still busy.
		repeat (3) send_tick(nop, took);
		issue(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
		issue(OP_WRITE, 8'h00, 1'b0, SDA_HIGH, 1'b1);
		issue(OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
		issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);

		// Zero lengths behave like one tick.
		write_timing('0, '0, '0, '0);
		issue(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
		issue(OP_WRITE, 8'h3C, 1'b0, SDA_LOW, 1'b1);
		issue(OP_READ, 8'h00, 1'b0, SDA_RAND, 1'b1);
		issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);

		write_timing(8'd2, 8'd1, 8'd3, 8'd6);
		issue(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
		issue(OP_WRITE, 8'h81, 1'b0, SDA_LOW, 1'b1);
		issue(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);

		// Fastest timing with no gaps and no stalls on either side.
		idle_pct = 0;
		write_timing(8'd1, 8'd1, 8'd1, 8'd1);
		target = items_sent + 150;
		while (items_sent < target)
			random_transfer();
		idle_pct = 10;

		while (items_sent < ITEM_GOAL) begin
			write_timing(rand_len(3), rand_len(3), rand_len(3), rand_len(8));
			target = items_sent + 100;
			while (items_sent < target)
				random_transfer();
		end

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_i2c_master_byte_controller OK");
		else
			$display("tb_i2c_master_byte_controller NOT OK");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb_i2c_master_byte_controller NOT OK");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_cmd_if.sv
hdl/i2cm_res_if.sv
hdl/i2cm_cfg.sv
hdl/i2cm_core.sv
hdl/i2c_master_byte_controller.sv
sim/i2cm_checker.sv
sim/tb_i2c_master_byte_controller.sv
